// ===== rtl/kbdl_pkg.sv =====
`default_nettype none
package kbdl_pkg;

  localparam int MAX_NEIGHBORS = 16;
  localparam int RANK_W        = $clog2(MAX_NEIGHBORS);
  localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
  localparam int IDX_W         = 32;
  localparam int DIST_W        = 40;
  localparam int K_W           = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [K_W-1:0]    K_RESET  = K_W'(16);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_OFFER = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [IDX_W-1:0]    point_index;
    logic [DIST_W-1:0]   distance_sq;
    logic [RANK_W-1:0]   rank;
  } in_t;

  typedef struct packed {
    logic                accepted;
    logic [CNT_W-1:0]    entry_count;
    logic [DIST_W-1:0]   cutoff;
    logic                read_valid;
    logic [IDX_W-1:0]    read_index;
    logic [DIST_W-1:0]   read_distance;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [DIST_W-1:0]   dist_sq;
  } entry_t;

  typedef struct packed {
    logic                offer_en;
    entry_t              cand;
  } cell_ctl_t;

  // clamp the written k to 1..MAX_NEIGHBORS
  function automatic logic [CNT_W-1:0] eff_k(input logic [K_W-1:0] k);
    logic [CNT_W-1:0] r;
    if (k == '0) begin
      r = CNT_W'(1);
    end else if (32'(k) > MAX_NEIGHBORS) begin
      r = CNT_W'(MAX_NEIGHBORS);
    end else begin
      r = CNT_W'(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kbdl_cell.sv =====
`default_nettype none
module kbdl_cell (
  input  wire                 clk,
  input  kbdl_pkg::cell_ctl_t ctl,
  input  wire                 occ,
  input  wire                 left_ins,
  input  kbdl_pkg::entry_t    left_ent,
  output logic                ins,
  output kbdl_pkg::entry_t    ent
);

  kbdl_pkg::entry_t ent_r;
  kbdl_pkg::entry_t ent_nxt;

  // candidate belongs here or further left
  assign ins = !(occ && (ent_r.dist_sq <= ctl.cand.dist_sq));
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.offer_en) begin
      if (left_ins) begin
        ent_nxt = left_ent;
      end else if (ins) begin
        ent_nxt = ctl.cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/k_best_distance_list_unit.sv =====
`default_nettype none
// k best distance list. Keeps the k nearest offers sorted in a row of
// compare-and-shift cells. A new command can be started in every cycle once
// busy is low (busy is registered: high during reset, it clears once reset is
// released). Each command gives exactly one result on out_data with out_strobe,
// registered through p_valid_r and out_strobe_r after the transfer; the receiver
// cannot stall, so out_data must be taken in that cycle. Throughput is one command
// per cycle, as the cell row shifts with each accepted offer. Write k only while no
// command is in flight; cfg_ready is low while start is high.
module k_best_distance_list_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  kbdl_pkg::in_t                    in_data,
  output logic                             out_strobe,
  output kbdl_pkg::out_t                   out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [kbdl_pkg::K_W-1:0]          cfg_data
);

  localparam int N = kbdl_pkg::MAX_NEIGHBORS;

  logic                           busy_r;
  logic [kbdl_pkg::K_W-1:0]       k_r;
  logic [kbdl_pkg::CNT_W-1:0]     count_r;
  logic [kbdl_pkg::CNT_W-1:0]     count_nxt;
  logic                           p_valid_r;
  kbdl_pkg::action_t              p_act_r;
  logic [kbdl_pkg::RANK_W-1:0]    p_rank_r;
  logic                           p_acc_r;
  logic                           out_strobe_r;
  kbdl_pkg::out_t                 out_r;
  kbdl_pkg::out_t                 out_nxt;

  logic                           accept;
  logic                           cfg_wr;
  logic [kbdl_pkg::CNT_W-1:0]     k_eff;
  logic [kbdl_pkg::DIST_W-1:0]    cutoff_c;
  logic [kbdl_pkg::CNT_W-1:0]     last_pos;
  kbdl_pkg::cell_ctl_t            ctl;
  logic                           offer_ok;
  logic [N-1:0]                   occ;
  logic [N-1:0]                   ins;
  kbdl_pkg::entry_t               ent [N];
  logic                           sorted_ok;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign k_eff     = kbdl_pkg::eff_k(k_r);
  assign last_pos  = count_r - kbdl_pkg::CNT_W'(1);
  assign cutoff_c  = ((count_r >= k_eff) && (count_r != '0)) ?
                     ent[last_pos[kbdl_pkg::RANK_W-1:0]].dist_sq : kbdl_pkg::DIST_MAX;

  assign offer_ok         = in_data.distance_sq < cutoff_c;
  assign ctl.offer_en     = accept && (in_data.action == kbdl_pkg::ACT_OFFER) && offer_ok;
  assign ctl.cand.idx     = in_data.point_index;
  assign ctl.cand.dist_sq = in_data.distance_sq;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      assign occ[gi] = count_r > kbdl_pkg::CNT_W'(gi);
      if (gi == 0) begin : g_head
        kbdl_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (occ[gi]),
          .left_ins (1'b0),
          .left_ent (ctl.cand),
          .ins      (ins[gi]),
          .ent      (ent[gi])
        );
      end else begin : g_body
        kbdl_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (occ[gi]),
          .left_ins (ins[gi-1]),
          .left_ent (ent[gi-1]),
          .ins      (ins[gi]),
          .ent      (ent[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr) begin
      if (count_r > kbdl_pkg::eff_k(cfg_data)) begin
        count_nxt = kbdl_pkg::eff_k(cfg_data);
      end
    end else if (accept && (in_data.action == kbdl_pkg::ACT_CLEAR)) begin
      count_nxt = '0;
    end else if (ctl.offer_en && (count_r < k_eff)) begin
      count_nxt = count_r + kbdl_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.entry_count = count_r;
    out_nxt.cutoff      = cutoff_c;
    case (p_act_r)
      kbdl_pkg::ACT_OFFER: begin
        out_nxt.accepted = p_acc_r;
      end
      kbdl_pkg::ACT_READ: begin
        if ({1'b0, p_rank_r} < count_r) begin
          out_nxt.read_valid    = 1'b1;
          out_nxt.read_index    = ent[p_rank_r].idx;
          out_nxt.read_distance = ent[p_rank_r].dist_sq;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      k_r          <= kbdl_pkg::K_RESET;
      count_r      <= '0;
      p_valid_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      count_r      <= count_nxt;
      p_valid_r    <= accept;
      out_strobe_r <= p_valid_r;
      if (cfg_wr) begin
        k_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_act_r  <= in_data.action;
      p_rank_r <= in_data.rank;
      p_acc_r  <= ctl.offer_en;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < N - 1; i++) begin
      if (occ[i+1] && (ent[i].dist_sq > ent[i+1].dist_sq)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_le_k: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= k_eff) else $error("entry count above k");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_ok) else $error("held entries out of order");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe_r) else $error("missing result two cycles after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(accept, 2)) else $error("result without a transfer");

  a_cutoff_max_when_short: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < k_eff) |-> (cutoff_c == kbdl_pkg::DIST_MAX))
    else $error("cutoff set while list not full");

endmodule
`default_nettype wire
